// ===== src/vfrim_pkg.sv =====
package vfrim_pkg;

    localparam int FRAME_BITS = 32;
    localparam int RATE_BITS  = 64;
    localparam int RATE_HALF  = RATE_BITS / 2;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = RATE_BITS;

    localparam logic [CFG_IDX_W-1:0] CFG_TIMELINE_COUNT = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_FIRST    = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LAST     = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_IN      = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_END     = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_NUM       = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_DEN       = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_END_HOLD       = 4'd7;

    typedef struct packed {
        logic ovf;
        logic absent;
    } t_tag;

endpackage

// ===== src/vfrim_div.sv =====
module vfrim_div #(
    parameter int F  = vfrim_pkg::FRAME_BITS,
    parameter int DW = vfrim_pkg::RATE_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  vfrim_pkg::t_tag    i_tag,
    input  logic [DW+F-1:0]    i_rem,
    input  logic [DW-1:0]      i_den,
    output logic               o_valid,
    output vfrim_pkg::t_tag    o_tag,
    output logic [F-1:0]       o_quo
);

    logic               w_valid [0:F];
    vfrim_pkg::t_tag    w_tag   [0:F];
    logic [DW+F-1:0]    w_rem   [0:F];
    logic [F-1:0]       w_quo   [0:F];

    logic               r_valid [1:F];
    vfrim_pkg::t_tag    r_tag   [1:F];
    logic [DW+F-1:0]    r_rem   [1:F];
    logic [F-1:0]       r_quo   [1:F];

    assign w_valid[0] = i_valid;
    assign w_tag[0]   = i_tag;
    assign w_rem[0]   = i_rem;
    assign w_quo[0]   = '0;

    for (genvar k = 0; k < F; k++) begin : g_step
        localparam int B = F - 1 - k;
        logic [DW+F-1:0] w_dsh;
        logic            w_ge;

        assign w_dsh = {{F{1'b0}}, i_den} << B;
        assign w_ge  = w_rem[k] >= w_dsh;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k+1] <= 1'b0;
            end else if (i_en) begin
                r_valid[k+1] <= w_valid[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_tag[k+1] <= w_tag[k];
                r_rem[k+1] <= w_ge ? (w_rem[k] - w_dsh) : w_rem[k];
                r_quo[k+1] <= w_quo[k] | ({{(F-1){1'b0}}, w_ge} << B);
            end
        end

        assign w_valid[k+1] = r_valid[k+1];
        assign w_tag[k+1]   = r_tag[k+1];
        assign w_rem[k+1]   = r_rem[k+1];
        assign w_quo[k+1]   = r_quo[k+1];
    end

    assign o_valid = w_valid[F];
    assign o_tag   = w_tag[F];
    assign o_quo   = w_quo[F];

endmodule

// ===== src/video_frame_rate_index_mapper.sv =====
// channel   dir  handshake             payload
// s         in   i_s_tvalid/o_s_tready tdata: frame
// m         out  o_m_tvalid/i_m_tready tuser: present; tdata: source_frame
// cfg       in   i_cfg_valid/o_cfg_ready index, data
// one beat accepted per cycle while m does not stall
// path: stages s0-s4, FRAME_BITS-stage restoring quotient pipeline, output register
// synchronous active-low reset clears valid bits and configuration registers
// a stall on m freezes the whole pipeline, nothing lost or repeated
module video_frame_rate_index_mapper #(
    parameter int FRAME_BITS = vfrim_pkg::FRAME_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [((FRAME_BITS+7)/8)*8-1:0]   i_s_tdata,   // frame
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [((FRAME_BITS+7)/8)*8-1:0]   o_m_tdata,   // source_frame
    output logic                              o_m_tuser,   // present
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [vfrim_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [vfrim_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int F      = FRAME_BITS;
    localparam int DW     = vfrim_pkg::RATE_BITS;
    localparam int RH     = vfrim_pkg::RATE_HALF;
    localparam int TD_W   = ((FRAME_BITS + 7) / 8) * 8;

    logic [F-1:0]    r_tl_count, r_rng_first, r_rng_last, r_src_in, r_src_end;
    logic [DW-1:0]   r_num, r_den;
    logic            r_end_hold;

    logic            w_adv;
    logic            r_s0_valid, r_s1_valid, r_s2_valid, r_s3_valid, r_s4_valid;
    logic [F-1:0]    r_s0_frame;
    logic [F-1:0]    r_s1_elapsed;
    logic            r_s1_absent, r_s2_absent, r_s3_absent;
    logic [RH+F-1:0] r_s2_p0, r_s2_p1;
    logic [DW+F-1:0] r_s3_t, r_s4_t;
    vfrim_pkg::t_tag r_s4_tag;

    logic            w_absent;
    logic            w_d_valid;
    vfrim_pkg::t_tag w_d_tag;
    logic [F-1:0]    w_d_quo;
    logic [F-1:0]    w_count, w_q;
    logic            r_out_valid, r_out_present;
    logic [F-1:0]    r_out_frame;
    logic            n_out_present;
    logic [F-1:0]    n_out_frame;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tl_count  <= '0;
            r_rng_first <= '0;
            r_rng_last  <= '1;
            r_src_in    <= '0;
            r_src_end   <= '0;
            r_num       <= '0;
            r_den       <= '0;
            r_end_hold  <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                vfrim_pkg::CFG_TIMELINE_COUNT: r_tl_count  <= i_cfg_data[F-1:0];
                vfrim_pkg::CFG_RANGE_FIRST:    r_rng_first <= i_cfg_data[F-1:0];
                vfrim_pkg::CFG_RANGE_LAST:     r_rng_last  <= i_cfg_data[F-1:0];
                vfrim_pkg::CFG_SOURCE_IN:      r_src_in    <= i_cfg_data[F-1:0];
                vfrim_pkg::CFG_SOURCE_END:     r_src_end   <= i_cfg_data[F-1:0];
                vfrim_pkg::CFG_RATE_NUM:       r_num       <= i_cfg_data[DW-1:0];
                vfrim_pkg::CFG_RATE_DEN:       r_den       <= i_cfg_data[DW-1:0];
                vfrim_pkg::CFG_END_HOLD:       r_end_hold  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign w_adv      = !r_out_valid || i_m_tready;
    assign o_s_tready = w_adv;

    assign w_absent = (r_s0_frame >= r_tl_count) || (r_s0_frame < r_rng_first)
                   || (r_s0_frame > r_rng_last) || (r_num == '0) || (r_den == '0)
                   || (r_src_in >= r_src_end);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
        end else if (w_adv) begin
            r_s0_valid <= i_s_tvalid;
            r_s1_valid <= r_s0_valid;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            r_s4_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s0_frame   <= i_s_tdata[F-1:0];
            r_s1_absent  <= w_absent;
            r_s1_elapsed <= r_s0_frame - r_rng_first;
            r_s2_absent  <= r_s1_absent;
            r_s2_p0      <= (RH+F)'(r_num[RH-1:0]) * (RH+F)'(r_s1_elapsed);
            r_s2_p1      <= (RH+F)'(r_num[DW-1:RH]) * (RH+F)'(r_s1_elapsed);
            r_s3_absent  <= r_s2_absent;
            r_s3_t       <= (DW+F)'(r_s2_p0) + ((DW+F)'(r_s2_p1) << RH);
            r_s4_t       <= r_s3_t;
            r_s4_tag.absent <= r_s3_absent;
            r_s4_tag.ovf    <= r_s3_t >= {r_den, {F{1'b0}}};
        end
    end

    vfrim_div #(
        .F  (F),
        .DW (DW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (r_s4_valid),
        .i_tag   (r_s4_tag),
        .i_rem   (r_s4_t),
        .i_den   (r_den),
        .o_valid (w_d_valid),
        .o_tag   (w_d_tag),
        .o_quo   (w_d_quo)
    );

    assign w_count = r_src_end - r_src_in;
    assign w_q     = (w_d_tag.ovf || (w_d_quo >= w_count)) ? w_count : w_d_quo;

    always_comb begin
        n_out_present = 1'b0;
        n_out_frame   = '0;
        if (!w_d_tag.absent) begin
            if (w_q == w_count) begin
                if (r_end_hold) begin
                    n_out_present = 1'b1;
                    n_out_frame   = r_src_end - F'(1);
                end
            end else begin
                n_out_present = 1'b1;
                n_out_frame   = r_src_in + w_q;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_present <= n_out_present;
            r_out_frame   <= n_out_frame;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_present;
    assign o_m_tdata  = TD_W'(r_out_frame);

`ifndef SYNTHESIS
    a_absent_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser) |-> (r_out_frame == '0))
        else $error("absent beat carries nonzero frame");

    a_in_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> (r_out_frame < r_src_end && r_out_frame >= r_src_in))
        else $error("source frame outside span");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid right after reset");
`endif

endmodule

// ===== test/frame_map_checker.sv =====
`timescale 1ns / 100ps

module frame_map_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    input  logic                             i_s_tready,
    input  logic [31:0]                      i_s_tdata,
    input  logic                             i_m_tvalid,
    input  logic                             i_m_tready,
    input  logic [31:0]                      i_m_tdata,
    input  logic                             i_m_tuser,
    input  logic                             i_cfg_valid,
    input  logic                             i_cfg_ready,
    input  logic [vfrim_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [vfrim_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                               o_errors,
    output int                               o_pending
);

    typedef struct packed {
        logic        present;
        logic [31:0] source_frame;
    } t_mapped;

    logic [31:0] timeline_count, first_frame, last_frame, src_in, src_end;
    logic [63:0] rate_num, rate_den;
    logic        hold_last;
    t_mapped     mapped_q[$];

    function automatic t_mapped map_frame(logic [31:0] frame);
        t_mapped     res;
        logic [31:0] span;
        logic [127:0] ticks, quot;
        res = '0;
        if (frame >= timeline_count || frame < first_frame || frame > last_frame)
            return res;
        if (rate_num == 0 || rate_den == 0 || src_in >= src_end)
            return res;
        span  = src_end - src_in;
        ticks = 128'(rate_num) * 128'(frame - first_frame);
        quot  = ticks / 128'(rate_den);
        if (quot >= 128'(span)) begin
            if (hold_last) begin
                res.present      = 1'b1;
                res.source_frame = src_end - 32'd1;
            end
        end else begin
            res.present      = 1'b1;
            res.source_frame = src_in + quot[31:0];
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_mapped got, want;
        if (!i_rst_n) begin
            timeline_count = '0;
            first_frame    = '0;
            last_frame     = '1;
            src_in         = '0;
            src_end        = '0;
            rate_num       = '0;
            rate_den       = '0;
            hold_last      = 1'b0;
            mapped_q.delete();
            o_errors  <= 0;
            o_pending <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    vfrim_pkg::CFG_TIMELINE_COUNT: timeline_count = i_cfg_data[31:0];
                    vfrim_pkg::CFG_RANGE_FIRST:    first_frame    = i_cfg_data[31:0];
                    vfrim_pkg::CFG_RANGE_LAST:     last_frame     = i_cfg_data[31:0];
                    vfrim_pkg::CFG_SOURCE_IN:      src_in         = i_cfg_data[31:0];
                    vfrim_pkg::CFG_SOURCE_END:     src_end        = i_cfg_data[31:0];
                    vfrim_pkg::CFG_RATE_NUM:       rate_num       = i_cfg_data;
                    vfrim_pkg::CFG_RATE_DEN:       rate_den       = i_cfg_data;
                    vfrim_pkg::CFG_END_HOLD:       hold_last      = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready)
                mapped_q.push_back(map_frame(i_s_tdata));
            if (i_m_tvalid && i_m_tready) begin
                got.present      = i_m_tuser;
                got.source_frame = i_m_tdata;
                if (mapped_q.size() == 0) begin
                    $display("%0t: unexpected beat present=%0b frame=%h",
                             $time, got.present, got.source_frame);
                    o_errors <= o_errors + 1;
                end else begin
                    want = mapped_q.pop_front();
                    if (got.present !== want.present ||
                        got.source_frame !== want.source_frame) begin
                        $display("%0t: expected present=%0b frame=%h, got present=%0b frame=%h",
                                 $time, want.present, want.source_frame,
                                 got.present, got.source_frame);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            o_pending <= mapped_q.size();
        end
    end
endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

    localparam logic [vfrim_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED = 4'd13;
    localparam int NO_IDLE = 0, SEND_IDLE = 1, RECV_IDLE = 2, BOTH_IDLE = 3;
    localparam int STALL_PHASE = 5;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             i_s_tvalid = 1'b0;
    logic                             o_s_tready;
    logic [31:0]                      i_s_tdata = '0;
    logic                             o_m_tvalid;
    logic                             i_m_tready = 1'b0;
    logic [31:0]                      o_m_tdata;
    logic                             o_m_tuser;
    logic                             i_cfg_valid = 1'b0;
    logic                             o_cfg_ready;
    logic [vfrim_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [vfrim_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    int errors, pending;
    int idle_mode = NO_IDLE;
    int phase_now = -1;
    int hold_off = 0;
    logic hold_done = 1'b0;
    logic [31:0] first_cur, last_cur;

    always #1 i_clk = ~i_clk;

    video_frame_rate_index_mapper u_dut (.*);

    frame_map_checker u_check (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid), .i_s_tready(o_s_tready), .i_s_tdata(i_s_tdata),
        .i_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready), .i_m_tdata(o_m_tdata),
        .i_m_tuser(o_m_tuser),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_errors(errors), .o_pending(pending)
    );

    // receiver side
    always @(posedge i_clk) begin
        if (phase_now == STALL_PHASE && !hold_done) begin
            hold_done  <= 1'b1;
            hold_off   <= 400;
            i_m_tready <= 1'b0;
        end else if (hold_off > 0) begin
            hold_off   <= hold_off - 1;
            i_m_tready <= 1'b0;
        end else if (idle_mode == RECV_IDLE)
            i_m_tready <= ($urandom_range(99, 0) >= 64);
        else if (idle_mode == BOTH_IDLE)
            i_m_tready <= ($urandom_range(99, 0) >= 26);
        else
            i_m_tready <= 1'b1;
    end

    initial begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

    function automatic logic [63:0] rand_wide(int shift);
        return {$urandom, $urandom} >> shift;
    endfunction

    task automatic write_reg(logic [vfrim_pkg::CFG_IDX_W-1:0] idx, logic [63:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_all(logic [31:0] tl, logic [31:0] rf, logic [31:0] rl,
                           logic [31:0] si, logic [31:0] se, logic [63:0] num,
                           logic [63:0] den, logic hold);
        write_reg(vfrim_pkg::CFG_TIMELINE_COUNT, {32'h0, tl});
        write_reg(vfrim_pkg::CFG_RANGE_FIRST, {$urandom, rf});
        write_reg(vfrim_pkg::CFG_RANGE_LAST, {32'h0, rl});
        write_reg(vfrim_pkg::CFG_SOURCE_IN, {32'h0, si});
        write_reg(vfrim_pkg::CFG_SOURCE_END, {32'h0, se});
        write_reg(vfrim_pkg::CFG_RATE_NUM, num);
        write_reg(vfrim_pkg::CFG_RATE_DEN, den);
        write_reg(vfrim_pkg::CFG_END_HOLD, {$urandom, 31'h0, hold});
        first_cur = rf;
        last_cur  = rl;
    endtask

    task automatic send_frame(logic [31:0] frame);
        int gap;
        gap = 0;
        if (idle_mode == SEND_IDLE && $urandom_range(99, 0) < 64)
            gap = $urandom_range(4, 1);
        else if (idle_mode == BOTH_IDLE && $urandom_range(99, 0) < 26)
            gap = $urandom_range(4, 1);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= frame;
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    task automatic drain;
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic random_config(int k);
        logic [31:0] tl, rf, rl, si, se;
        logic [63:0] num, den;
        int a, b;
        tl = ($urandom_range(3, 0) == 0) ? $urandom : 32'hffffffff;
        rf = ($urandom_range(3, 0) == 0) ? 32'h0 : $urandom;
        rl = ($urandom_range(2, 0) == 0) ? 32'hffffffff : rf + $urandom_range(5000, 0);
        si = $urandom;
        se = si + $urandom_range(3000, 1);
        if (se < si) se = 32'hffffffff;
        a = $urandom_range(63, 0);
        b = a + $urandom_range(4, 0) - 2;
        if (b < 0) b = 0;
        if (b > 63) b = 63;
        num = rand_wide(a) | 64'h1;
        den = rand_wide(b) | 64'h1;
        case (k % 8)
            0: num = '0;
            1: den = '0;
            2: se = si - $urandom_range(1, 0);
            3: begin num = '1; den = '1; end
            4: tl = $urandom_range(100, 0);
            default: ;
        endcase
        if ($urandom_range(4, 0) == 0) write_reg(CFG_UNMAPPED, rand_wide(0));
        set_all(tl, rf, rl, si, se, num, den, $urandom_range(1, 0));
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part
        set_all('1, '0, '1, '0, '1, '1, '1, 1'b1);
        send_frame(32'h0);
        send_frame(32'hfffffffe);
        send_frame(32'hffffffff);
        send_frame(32'h5555aaaa);
        drain();
        set_all(32'd100, 32'd10, 32'd50, 32'd5, 32'd20, 64'd3, 64'd2, 1'b0);
        send_frame(32'd9);
        send_frame(32'd10);
        send_frame(32'd51);
        send_frame(32'd100);
        send_frame(32'd20);
        send_frame(32'd19);
        drain();
        write_reg(vfrim_pkg::CFG_END_HOLD, 64'd1);
        send_frame(32'd20);
        send_frame(32'd50);
        drain();
        write_reg(vfrim_pkg::CFG_RATE_NUM, 64'd0);
        send_frame(32'd12);
        drain();
        write_reg(vfrim_pkg::CFG_RATE_NUM, 64'd3);
        write_reg(vfrim_pkg::CFG_RATE_DEN, 64'd0);
        send_frame(32'd12);
        drain();
        write_reg(vfrim_pkg::CFG_RATE_DEN, 64'd2);
        write_reg(vfrim_pkg::CFG_SOURCE_END, 64'd5);
        send_frame(32'd12);
        drain();

        // random part
        for (int ph = 0; ph < 24; ph++) begin
            idle_mode = ph % 4;
            random_config(ph);
            phase_now = ph;
            for (int n = 0; n < 80; n++) begin
                if (ph == 9 && n == 40) drain();
                case ($urandom_range(9, 0))
                    0: send_frame($urandom);
                    1: send_frame(first_cur - 32'd1);
                    2: send_frame(last_cur + 32'd1);
                    default: send_frame(first_cur + $urandom_range(3000, 0));
                endcase
            end
            drain();
        end
        idle_mode = NO_IDLE;
        repeat (50) @(posedge i_clk);

        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

// ===== video_frame_rate_index_mapper.f =====
src/vfrim_pkg.sv
src/vfrim_div.sv
src/video_frame_rate_index_mapper.sv
test/frame_map_checker.sv
test/testbench.sv
